// ===== src/rta_pkg.sv =====
package rta_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 6;
  localparam int unsigned ShamtW = 5;
  localparam int unsigned StatW = 3;
  localparam int unsigned CntW = 6;
  localparam int unsigned FifoDepthDef = 2;

  typedef enum logic [FuncW-1:0] {
    F_SLL   = 6'h00, F_SRL  = 6'h02, F_SRA  = 6'h03, F_SLLV = 6'h04,
    F_SRLV  = 6'h06, F_SRAV = 6'h07, F_JR   = 6'h08, F_JALR = 6'h09,
    F_MFHI  = 6'h10, F_MTHI = 6'h11, F_MFLO = 6'h12, F_MTLO = 6'h13,
    F_MULT  = 6'h18, F_MULTU = 6'h19, F_DIV = 6'h1A, F_DIVU = 6'h1B,
    F_ADD   = 6'h20, F_ADDU = 6'h21, F_SUB  = 6'h22, F_SUBU = 6'h23,
    F_AND   = 6'h24, F_OR   = 6'h25, F_XOR  = 6'h26, F_NOR  = 6'h27,
    F_SLT   = 6'h2A, F_SLTU = 6'h2B
  } func_t;

  typedef enum logic [StatW-1:0] {
    ST_OK = 3'd0, ST_OVF = 3'd1, ST_DIVZ = 3'd2, ST_SHAMT = 3'd3, ST_UNSUP = 3'd4
  } status_t;

  // Kind of work the back end performs for one item.
  typedef enum logic [2:0] {
    K_DONE, K_MFHI, K_MFLO, K_MTHI, K_MTLO, K_MUL, K_DIV
  } kind_t;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    kind_t            kind;
    logic             sgn;
    logic [DataW-1:0] res;
    status_t          st;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } op_t;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIX} bstate_t;

endpackage

// ===== src/rta_front.sv =====
module rta_front
  import rta_pkg::*;
(
  input  logic [FuncW-1:0]  func,
  input  logic [DataW-1:0]  rs,
  input  logic [DataW-1:0]  rt,
  input  logic [ShamtW-1:0] sa,
  output op_t               op
);
  logic [ShamtW-1:0] vs;
  logic              need_z;
  logic [DataW-1:0]  sum, dif;

  assign vs = rs[ShamtW-1:0];
  assign sum = rs + rt;
  assign dif = rs - rt;

  always_comb begin
    need_z = 1'b0;
    case (func)
      F_SLLV, F_SRLV, F_SRAV, F_ADD, F_ADDU, F_SUB, F_SUBU,
      F_AND, F_OR, F_XOR, F_NOR, F_SLT, F_SLTU: need_z = 1'b1;
      default: need_z = 1'b0;
    endcase
  end

  always_comb begin
    op.kind = K_DONE;
    op.sgn = 1'b0;
    op.res = '0;
    op.st = ST_OK;
    op.a = rs;
    op.b = rt;
    if (need_z && (sa != '0)) begin
      op.st = ST_SHAMT;
    end else begin
      case (func)
        F_SLL:  op.res = rt << sa;
        F_SRL:  op.res = rt >> sa;
        F_SRA:  op.res = $unsigned($signed(rt) >>> sa);
        F_SLLV: op.res = rt << vs;
        F_SRLV: op.res = rt >> vs;
        F_SRAV: op.res = $unsigned($signed(rt) >>> vs);
        F_JR, F_JALR: op.res = rs;
        F_MFHI: op.kind = K_MFHI;
        F_MFLO: op.kind = K_MFLO;
        F_MTHI: begin op.kind = K_MTHI; op.res = rs; end
        F_MTLO: begin op.kind = K_MTLO; op.res = rs; end
        F_MULT: begin op.kind = K_MUL; op.sgn = 1'b1; end
        F_MULTU: op.kind = K_MUL;
        F_DIV, F_DIVU: begin
          if (rt == '0) begin
            op.st = ST_DIVZ;
          end else begin
            op.kind = K_DIV;
            op.sgn = (func == F_DIV);
          end
        end
        F_ADD: begin
          op.res = sum;
          if (((rs ^ sum) & (rt ^ sum)) >> (DataW-1) != '0) op.st = ST_OVF;
        end
        F_ADDU: op.res = sum;
        F_SUB: begin
          op.res = dif;
          if (((rs ^ rt) & (rs ^ dif)) >> (DataW-1) != '0) op.st = ST_OVF;
        end
        F_SUBU: op.res = dif;
        F_AND:  op.res = rs & rt;
        F_OR:   op.res = rs | rt;
        F_XOR:  op.res = rs ^ rt;
        F_NOR:  op.res = ~(rs | rt);
        F_SLT:  op.res = {{(DataW-1){1'b0}}, ($signed(rs) < $signed(rt))};
        F_SLTU: op.res = {{(DataW-1){1'b0}}, (rs < rt)};
        default: op.st = ST_UNSUP;
      endcase
    end
    if (op.st != ST_OK) op.res = '0;
  end
endmodule

// ===== src/rta_fifo.sv =====
module rta_fifo
  import rta_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  op_t  wr_data,
  output logic full,
  input  logic rd_en,
  output op_t  rd_data,
  output logic empty
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  op_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

// ===== src/rta_back.sv =====
module rta_back
  import rta_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  input  op_t              op,
  output logic             op_take,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [DataW-1:0] res_value,
  output logic [StatW-1:0] res_status
);
  bstate_t state_r, state_nxt;
  logic [DataW-1:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [DataW-1:0] acc_r, acc_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt;
  logic vld_r, vld_nxt;
  logic [DataW-1:0] val_r, val_nxt;
  logic [StatW-1:0] st_r, st_nxt;
  logic out_free;
  logic [DataW:0] madd, dsub;
  logic [DataW-1:0] ma, mb;
  logic is_div_r, is_div_nxt;
  logic [2*DataW-1:0] prod;
  logic [DataW-1:0] hi_fin, lo_fin;

  assign out_free = !vld_r || res_ready;
  assign res_valid = vld_r;
  assign res_value = val_r;
  assign res_status = st_r;
  assign ma = (op.sgn && op.a[DataW-1]) ? -op.a : op.a;
  assign mb = (op.sgn && op.b[DataW-1]) ? -op.b : op.b;
  // one shift-add step of the multiplier, one restoring step of the divider
  assign madd = {1'b0, acc_r} + (q_r[0] ? {1'b0, d_r} : '0);
  assign dsub = {acc_r, q_r[DataW-1]} - {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (op_valid && out_free) begin
        if (op.kind == K_MUL) state_nxt = S_MUL;
        else if (op.kind == K_DIV) state_nxt = S_DIV;
      end
      S_MUL, S_DIV: if (cnt_r == CntW'(DataW-1)) state_nxt = S_FIX;
      S_FIX: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    hi_nxt = hi_r; lo_nxt = lo_r;
    acc_nxt = acc_r; q_nxt = q_r; d_nxt = d_r; cnt_nxt = cnt_r;
    neg_q_nxt = neg_q_r; neg_r_nxt = neg_r_r;
    vld_nxt = vld_r && !res_ready;
    val_nxt = val_r; st_nxt = st_r;
    op_take = 1'b0;
    case (state_r)
      S_IDLE: if (op_valid && out_free) begin
        op_take = 1'b1;
        acc_nxt = '0; q_nxt = ma; d_nxt = mb; cnt_nxt = '0;
        neg_q_nxt = op.sgn && (op.a[DataW-1] ^ op.b[DataW-1]);
        neg_r_nxt = op.sgn && op.a[DataW-1];
        if (op.kind != K_MUL && op.kind != K_DIV) begin
          vld_nxt = 1'b1;
          st_nxt = op.st;
          val_nxt = op.res;
          case (op.kind)
            K_MFHI: val_nxt = hi_r;
            K_MFLO: val_nxt = lo_r;
            K_MTHI: hi_nxt = op.a;
            K_MTLO: lo_nxt = op.a;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        {acc_nxt, q_nxt} = {madd, q_r[DataW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
      end
      S_DIV: begin
        if (!dsub[DataW]) begin
          acc_nxt = dsub[DataW-1:0];
          q_nxt = {q_r[DataW-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[DataW-2:0], q_r[DataW-1]};
          q_nxt = {q_r[DataW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_FIX: begin
        vld_nxt = 1'b1;
        val_nxt = '0;
        st_nxt = ST_OK;
      end
      default: ;
    endcase
  end

  assign prod = {acc_r, q_r};
  assign is_div_nxt = (state_r == S_IDLE) ? (op.kind == K_DIV) : is_div_r;

  // product: negate 64 bits; quotient/remainder: negate separately
  always_comb begin
    if (is_div_r) begin
      lo_fin = neg_q_r ? -q_r : q_r;
      hi_fin = neg_r_r ? -acc_r : acc_r;
    end else begin
      {hi_fin, lo_fin} = neg_q_r ? -prod : prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hi_r <= '0;
      lo_r <= '0;
      vld_r <= 1'b0;
      is_div_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hi_r <= (state_r == S_FIX) ? hi_fin : hi_nxt;
      lo_r <= (state_r == S_FIX) ? lo_fin : lo_nxt;
      vld_r <= vld_nxt;
      is_div_r <= is_div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; q_r <= q_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    neg_q_r <= neg_q_nxt; neg_r_r <= neg_r_nxt;
    val_r <= val_nxt; st_r <= st_nxt;
  end
endmodule

// ===== src/r_type_alu_hi_lo_unit.sv =====
// R-type ALU with a HI/LO pair. Each input transaction carries one instruction
// (function code, rs and rt values, shift field) and yields exactly one output
// transaction with the destination value and a status code (0 ok, 1 overflow,
// 2 divide by zero, 3 nonzero shift field where it must be zero, 4 unsupported).
// A front end decodes and finishes all combinational work; a small queue feeds a
// back end that owns HI/LO. Simple operations pass through the queue and the
// output register and can stream one per cycle while the output is not stalled
// and the back end is idle; mult/multu and div/divu take an issue step, a
// shift-add or restoring divide loop and a fix-up step, and the back end takes
// no new item until it is through with one of those.
module r_type_alu_hi_lo_unit
  import rta_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // func[5:0], rs_value[37:6], rt_value[69:38], shift_amount[74:70]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_value[31:0], status[34:32]
);
  op_t  f_op, q_op;
  logic q_full, q_empty, take;
  logic [DataW-1:0] rv;
  logic [StatW-1:0] rst_code;

  rta_front u_front (
    .func(in_tdata[5:0]), .rs(in_tdata[37:6]), .rt(in_tdata[69:38]),
    .sa(in_tdata[74:70]), .op(f_op)
  );

  assign in_tready = !q_full;

  rta_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_tvalid && !q_full), .wr_data(f_op), .full(q_full),
    .rd_en(take), .rd_data(q_op), .empty(q_empty)
  );

  rta_back u_back (
    .clk(clk), .rst_n(rst_n),
    .op_valid(!q_empty), .op(q_op), .op_take(take),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_value(rv), .res_status(rst_code)
  );

  assign out_tdata = {5'b0, rst_code, rv};

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n) take |-> !q_empty)
    else $error("back end took from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] != ST_OK |-> out_tdata[31:0] == 32'd0)
    else $error("error result not zero");
endmodule
